FILE: hdl/lspe_pkg.sv
// ----------------------------------------------------------------------------
// lspe_pkg: shared types, constants and pattern tables for the line sensor
// position error block.
// ----------------------------------------------------------------------------
package lspe_pkg;

  // Sensor bar geometry
  localparam int unsigned NumLanes    = 12;
  localparam int unsigned GroupSize   = 4;
  localparam int unsigned NumGroups   = NumLanes / GroupSize;
  localparam logic [13:0] SensorMask  = 14'h3FFC;
  localparam logic [7:0]  CenterOffset = 8'd13;

  // Divider sizing: dividend is 2 * sum of sensor indexes (max 156)
  localparam int unsigned DivSteps = 8;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LANE  = 7'b0000010,
    S_PART  = 7'b0000100,
    S_TOTAL = 7'b0001000,
    S_START = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } lspe_state_e;

  // Merge stage controls
  typedef struct packed {
    logic part_load;
    logic total_load;
  } lspe_merge_ctrl_t;

  // Divider request and response
  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [3:0] divisor;
  } lspe_div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
  } lspe_div_rsp_t;

  // Bit-reverse one byte (first received bit lands in the MSB)
  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = b[k];
    end
    return r;
  endfunction

  // Centered white-line patterns (raw reading, before inversion)
  function automatic logic is_white(input logic [13:0] r);
    return r inside {14'h0C00, 14'h0600, 14'h0E00, 14'h0F00, 14'h0400,
                     14'h0700, 14'h0380, 14'h0300, 14'h0780, 14'h0100,
                     14'h0180, 14'h01C0, 14'h00C0, 14'h03C0, 14'h0080,
                     14'h00E0, 14'h0060, 14'h0070, 14'h00F0, 14'h0020};
  endfunction

  // Centered black-line patterns (raw reading, before inversion)
  function automatic logic is_black(input logic [13:0] r);
    return r inside {14'h33FC, 14'h39FC, 14'h31FC, 14'h3BFC, 14'h38FC,
                     14'h3C7C, 14'h3CFC, 14'h3EFC, 14'h3E7C, 14'h3E3C,
                     14'h3F3C, 14'h3F7C, 14'h3F1C, 14'h3F9C, 14'h3F8C,
                     14'h3FDC};
  endfunction

  // On-line patterns: singles, pairs and triples near the center
  function automatic logic is_online(input logic [13:0] r);
    return r inside {14'h0C00, 14'h0600, 14'h0300, 14'h0180, 14'h00C0,
                     14'h0060, 14'h0030, 14'h0E00, 14'h0700, 14'h0380,
                     14'h01C0, 14'h00E0, 14'h0070, 14'h0800, 14'h0400,
                     14'h0200, 14'h0100, 14'h0080, 14'h0040, 14'h0020,
                     14'h0010};
  endfunction

endpackage

FILE: hdl/line_sensor_position_error.sv
// ----------------------------------------------------------------------------
// line_sensor_position_error: line position from a 12-sensor bar
// Input channel (in_valid_i/in_ready_o) carries one beat per sensor frame:
// the two raw shift-register bytes and a fallback error. Output channel
// (out_valid_o/out_ready_i) returns one beat per frame: the processed
// reading, the centroid error, the out-of-line flag and the track mode.
// The beat is reversed, masked and classified into the frame register at the
// accepting edge; then it passes through the lane registers, the two levels
// of the adder tree, the divider start, the bit-serial divider, the hand-off
// to the output stage and the output register. One frame is in flight at a
// time and the sequencer returns to idle as the output register loads, so
// no new frame is accepted until the current one reaches the output
// register. The output register decouples the sides: the next frame is
// accepted while a result waits, and if the receiver stalls the finished
// frame waits before the output register. Reset clears the track mode to
// white line and enables pattern-driven mode switching.
// The configuration register is written by cfg_we_i with cfg_wdata_i.
// ----------------------------------------------------------------------------
module line_sensor_position_error (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        left_byte_i,
  input  logic [7:0]        right_byte_i,
  input  logic signed [7:0] fallback_error_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [13:0]       sensor_bits_o,
  output logic signed [7:0] position_error_o,
  output logic              out_of_line_o,
  output logic              black_line_mode_o
);
  import lspe_pkg::*;

  lspe_state_e      state_q, state_d;
  logic             inv_en_q;
  logic             black_q, black_d;
  logic             in_fire;
  logic             out_load;
  logic [15:0]      raw_word;
  logic [13:0]      raw;
  logic [13:0]      reading_q;
  logic [7:0]       fb_q;
  logic             item_black_q;
  lspe_merge_ctrl_t merge_ctrl;
  lspe_div_req_t    div_req;
  lspe_div_rsp_t    div_rsp;
  logic [NumLanes-1:0][3:0] lane_weight;
  logic [NumLanes-1:0]      lane_hit;
  logic [6:0]       sum;
  logic [3:0]       count;
  logic             out_valid_q;
  logic [13:0]      out_bits_q;
  logic [7:0]       out_err_q;
  logic             out_ool_q;
  logic             out_black_q;
  logic [7:0]       err_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      inv_en_q <= cfg_wdata_i;
    end
  end

  // Reverse, pack and mask; track mode update from raw pattern
  assign raw_word = {rev8(left_byte_i), rev8(right_byte_i)};
  assign raw      = raw_word[13:0] & SensorMask;

  always_comb begin
    black_d = black_q;
    if (inv_en_q) begin
      if (is_white(raw)) begin
        black_d = 1'b0;
      end else if (is_black(raw)) begin
        black_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= 1'b0;
    end else if (in_fire) begin
      black_q <= black_d;
    end
  end

  // Frame register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      reading_q    <= black_d ? (raw ^ SensorMask) : raw;
      fb_q         <= fallback_error_i;
      item_black_q <= black_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_LANE;
      S_LANE:  state_d = S_PART;
      S_PART:  state_d = S_TOTAL;
      S_TOTAL: state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_rsp.done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Lanes: sensor k (1..12) sits at bit 14-k with weight k
  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    lspe_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (state_q == S_LANE),
      .sense_i  (reading_q[13-k]),
      .weight_i (4'(k + 1)),
      .weight_o (lane_weight[k]),
      .hit_o    (lane_hit[k])
    );
  end

  // Merge tree
  assign merge_ctrl.part_load  = (state_q == S_PART);
  assign merge_ctrl.total_load = (state_q == S_TOTAL);

  lspe_merge u_merge (
    .clk_i    (clk_i),
    .ctrl_i   (merge_ctrl),
    .weight_i (lane_weight),
    .hit_i    (lane_hit),
    .sum_o    (sum),
    .count_o  (count)
  );

  // Divider: floor(2 * sum / count)
  assign div_req.start    = (state_q == S_START);
  assign div_req.dividend = {sum, 1'b0};
  assign div_req.divisor  = count;

  lspe_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign err_d = (count == 4'd0) ? fb_q : (div_rsp.quotient - CenterOffset);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bits_q  <= reading_q;
      out_err_q   <= err_d;
      out_ool_q   <= !is_online(reading_q);
      out_black_q <= item_black_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sensor_bits_o     = out_bits_q;
  assign position_error_o  = out_err_q;
  assign out_of_line_o     = out_ool_q;
  assign black_line_mode_o = out_black_q;

endmodule

FILE: hdl/lspe_lane.sv
// ----------------------------------------------------------------------------
// lspe_lane: one sensor lane
// Registers the sensor's weight when it is set, and its hit flag.
// ----------------------------------------------------------------------------
module lspe_lane (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       sense_i,
  input  logic [3:0] weight_i,
  output logic [3:0] weight_o,
  output logic       hit_o
);

  logic [3:0] weight_q;
  logic       hit_q;

  // Capture contribution of this sensor
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      weight_q <= sense_i ? weight_i : 4'd0;
      hit_q    <= sense_i;
    end
  end

  assign weight_o = weight_q;
  assign hit_o    = hit_q;

endmodule

FILE: hdl/lspe_merge.sv
// ----------------------------------------------------------------------------
// lspe_merge: two-level registered adder tree over the lane results
// First level sums groups of four lanes, second level sums the groups.
// ----------------------------------------------------------------------------
module lspe_merge (
  input  logic                                   clk_i,
  input  lspe_pkg::lspe_merge_ctrl_t             ctrl_i,
  input  logic [lspe_pkg::NumLanes-1:0][3:0]     weight_i,
  input  logic [lspe_pkg::NumLanes-1:0]          hit_i,
  output logic [6:0]                             sum_o,
  output logic [3:0]                             count_o
);
  import lspe_pkg::*;

  logic [NumGroups-1:0][5:0] psum_d, psum_q;
  logic [NumGroups-1:0][2:0] pcnt_d, pcnt_q;
  logic [6:0]                sum_d, sum_q;
  logic [3:0]                cnt_d, cnt_q;

  // Group partial sums
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      psum_d[g] = 6'(weight_i[g*GroupSize])   + 6'(weight_i[g*GroupSize+1])
                + 6'(weight_i[g*GroupSize+2]) + 6'(weight_i[g*GroupSize+3]);
      pcnt_d[g] = 3'(hit_i[g*GroupSize])   + 3'(hit_i[g*GroupSize+1])
                + 3'(hit_i[g*GroupSize+2]) + 3'(hit_i[g*GroupSize+3]);
    end
  end

  // Final totals
  always_comb begin
    sum_d = 7'(psum_q[0]) + 7'(psum_q[1]) + 7'(psum_q[2]);
    cnt_d = 4'(pcnt_q[0]) + 4'(pcnt_q[1]) + 4'(pcnt_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.part_load) begin
      psum_q <= psum_d;
      pcnt_q <= pcnt_d;
    end
    if (ctrl_i.total_load) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = cnt_q;

endmodule

FILE: hdl/lspe_divider.sv
// ----------------------------------------------------------------------------
// lspe_divider: restoring divider, one quotient bit per cycle
// 8-bit dividend by 4-bit divisor; quotient valid while done is set.
// ----------------------------------------------------------------------------
module lspe_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lspe_pkg::lspe_div_req_t req_i,
  output lspe_pkg::lspe_div_rsp_t rsp_o
);
  import lspe_pkg::*;

  logic [7:0] dvd_q;
  logic [3:0] div_q;
  logic [3:0] rem_q;
  logic [2:0] step_q;
  logic       busy_q;
  logic       done_q;
  logic [4:0] rem_shift;
  logic       fits;

  // One restoring step
  assign rem_shift = {rem_q, dvd_q[7]};
  assign fits      = rem_shift >= {1'b0, div_q};

  // Control: step counter runs through DivSteps steps, then done is held until the next start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'(DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: dividend shifts out, quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[6:0], fits};
      rem_q <= fits ? 4'(rem_shift - {1'b0, div_q}) : rem_shift[3:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

FILE: hdl/lspe_checker.sv
// ----------------------------------------------------------------------------
// lspe_checker: port-level checks for line_sensor_position_error
// Watches the output channel and the result fields over time.
// ----------------------------------------------------------------------------
module lspe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [13:0]       sensor_bits_o,
  input logic signed [7:0] position_error_o,
  input logic              out_of_line_o,
  input logic              black_line_mode_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sensor_bits_o)
      && $stable(position_error_o) && $stable(out_of_line_o)
      && $stable(black_line_mode_o))
    else $error("output beat changed while stalled");

  // Only sensor bits 13..2 can be set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sensor_bits_o[1:0] == 2'b00)
    else $error("reading has bits outside the sensor field");

  // Centroid error stays within the bar when any sensor is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sensor_bits_o != 14'd0)
      |-> (position_error_o >= -8'sd11) && (position_error_o <= 8'sd11))
    else $error("position error out of range");

  // An empty reading is never on the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sensor_bits_o == 14'd0) |-> out_of_line_o)
    else $error("empty reading flagged on line");

endmodule

bind line_sensor_position_error lspe_checker u_lspe_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .sensor_bits_o     (sensor_bits_o),
  .position_error_o  (position_error_o),
  .out_of_line_o     (out_of_line_o),
  .black_line_mode_o (black_line_mode_o)
);
